// File: src/pdc_pkg.sv
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int COORD_W   = 16;
  localparam int EPS_W     = 16;
  localparam int MINP_W    = 10;
  localparam int ID_W      = 5;
  localparam int COUNT_W   = 10;
  localparam int KEPT_W    = 5;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_EPS_MM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 1'd1;

  localparam logic KIND_ASSIGN  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd800;
  localparam logic [MINP_W-1:0] MINP_RESET = 10'd5;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    cluster_id;
    logic [COUNT_W-1:0] cluster_count;
    logic [KEPT_W-1:0]  kept_index;
    logic               dropped;
  } result_t;

endpackage

// File: src/point_distance_clustering_core.sv
`timescale 1ns / 1ps
// Point distance clustering core.
// in_*  : one point per item, tdata = {y_mm, x_mm}, tlast marks the frame's last point.
// out_* : one assignment item per point (tuser = 0); after a frame's last point one
//         summary item (tuser = 1) per kept cluster in creation order. tlast marks the
//         final item caused by each input point.
// cfg_* : register writes, index 0 eps_mm, index 1 minimum cluster size; always ready.
// Each point is compared against every stored point of the frame through the point
// memory, one read per cycle. Its assignment item follows the scan and the decide
// state, with an increment state added when it joins an existing cluster. A frame end
// adds a sweep of the cluster size memory, a read and a check state per open cluster.
// One point is worked on at a time; in_tready is high only while the core waits for a
// point, so the next point is taken only after its last item enters the output register.
// Results leave through an output register and a one-deep pending result, so a stalled
// receiver only holds the core at the point where a further result must be pushed.
// Reset (synchronous, rst_n low) empties the frame, restores eps_mm = 800 and the
// minimum cluster size 5 and drops any waiting result. No memory clearing pass is needed.
module point_distance_clustering_core
  import pdc_pkg::*;
#(
  parameter int PT_DEPTH     = 512,
  parameter int MAX_CLUSTERS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] x_mm, [31:16] y_mm
  input  logic                  in_tlast,   // frame_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] cluster_id, [14:5] cluster_count,
                                            // [19:15] kept_index, [20] dropped, rest 0
  output logic                  out_tuser,  // [0] kind
  output logic                  out_tlast,  // run_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PADDR_W = $clog2(PT_DEPTH);
  localparam int PCNT_W  = $clog2(PT_DEPTH + 1);
  localparam int CID_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int COPEN_W = $clog2(MAX_CLUSTERS + 1);
  localparam int CNT_EXT_W = (PCNT_W > COUNT_W) ? PCNT_W : COUNT_W + 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_INC, ST_SUM_RD, ST_SUM_CHK, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CID_W-1:0]          cl;
  } point_t;

  // memories
  point_t            pt_mem [PT_DEPTH];
  logic [PCNT_W-1:0] cs_mem [MAX_CLUSTERS];
  point_t            pt_q;
  logic [PCNT_W-1:0] cs_q;

  state_t                    state_r;
  logic [EPS_W-1:0]          eps_r;
  logic [MINP_W-1:0]         minp_r;
  logic [SQ_W-1:0]           eps2_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic                      last_r;
  logic [PCNT_W-1:0]         points_held_r;
  logic [COPEN_W-1:0]        clusters_open_r;
  logic [PCNT_W-1:0]         rd_idx_r;
  logic                      v1_r, v2_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic [CID_W-1:0]          cl2_r;
  logic                      best_valid_r;
  logic [CID_W-1:0]          best_r;
  logic [CID_W-1:0]          id_r;
  logic [COPEN_W-1:0]        sidx_r;
  logic [COPEN_W-1:0]        kept_r;
  result_t                   pend_r;
  result_t                   out_r;
  logic                      out_valid_r;
  logic                      out_last_r;

  // scan datapath
  logic                      issue_en;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [COORD_W-1:0]        mx, my;
  logic [SQ_W:0]             dsum;
  logic                      hit;

  // decision
  logic                      pt_full, cl_full, drop_c, new_c;
  logic [CID_W-1:0]          id_c;
  logic                      pt_we;
  logic                      cs_we;
  logic [CID_W-1:0]          cs_waddr;
  logic [PCNT_W-1:0]         cs_wdata;
  logic                      cs_re;
  logic [CID_W-1:0]          cs_raddr;
  logic                      sum_more;
  logic                      keep;
  logic [COUNT_W-1:0]        count_sat;
  logic                      out_free;
  logic                      push;
  result_t                   summary;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_r.dropped, out_r.kept_index,
                                   out_r.cluster_count, out_r.cluster_id});
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;

  assign out_free = !out_valid_r || out_tready;

  // scan: read issue, then squares, then compare
  assign issue_en = (state_r == ST_SCAN) && (rd_idx_r < points_held_r);

  always_comb begin
    dx = DIFF_W'(x_r) - DIFF_W'(pt_q.x);
    dy = DIFF_W'(y_r) - DIFF_W'(pt_q.y);
    mx = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    my = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    dsum = (SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqy_r);
    hit  = dsum < (SQ_W+1)'(eps2_r);
  end

  always_comb begin
    pt_full = (points_held_r == PCNT_W'(PT_DEPTH));
    cl_full = (clusters_open_r == COPEN_W'(MAX_CLUSTERS));
    drop_c  = pt_full || (!best_valid_r && cl_full);
    new_c   = !pt_full && !best_valid_r && !cl_full;
    id_c    = best_valid_r ? best_r : CID_W'(clusters_open_r);
    pt_we   = (state_r == ST_DECIDE) && !drop_c;

    cs_we    = 1'b0;
    cs_waddr = id_c;
    cs_wdata = PCNT_W'(1);
    if (state_r == ST_DECIDE && new_c) begin
      cs_we = 1'b1;
    end else if (state_r == ST_INC) begin
      cs_we    = 1'b1;
      cs_waddr = id_r;
      cs_wdata = cs_q + PCNT_W'(1);
    end

    sum_more = (sidx_r < clusters_open_r);
    cs_re    = 1'b0;
    cs_raddr = best_r;
    if (state_r == ST_DECIDE && best_valid_r && !pt_full) begin
      cs_re = 1'b1;
    end else if (state_r == ST_SUM_RD && sum_more) begin
      cs_re    = 1'b1;
      cs_raddr = CID_W'(sidx_r);
    end

    keep = (CNT_EXT_W'(cs_q) >= CNT_EXT_W'(minp_r));
    count_sat = (CNT_EXT_W'(cs_q) > CNT_EXT_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cs_q);
    summary.kind          = KIND_SUMMARY;
    summary.cluster_id    = ID_W'(sidx_r);
    summary.cluster_count = count_sat;
    summary.kept_index    = KEPT_W'(kept_r);
    summary.dropped       = 1'b0;

    push = out_free && ((state_r == ST_FLUSH) || (state_r == ST_SUM_CHK && keep));
  end

  // point memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[points_held_r[PADDR_W-1:0]] <= '{x: x_r, y: y_r, cl: id_c};
    end
    if (issue_en) begin
      pt_q <= pt_mem[rd_idx_r[PADDR_W-1:0]];
    end
  end

  // cluster size memory; the FSM never reads and writes one entry in the same cycle
  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= cs_wdata;
    end
    if (cs_re) begin
      cs_q <= cs_mem[cs_raddr];
    end
  end

  // squares and compare pipeline payload
  always_ff @(posedge clk) begin
    eps2_r <= SQ_W'(eps_r) * SQ_W'(eps_r);
    sqx_r  <= SQ_W'(mx) * SQ_W'(mx);
    sqy_r  <= SQ_W'(my) * SQ_W'(my);
    cl2_r  <= pt_q.cl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      eps_r           <= EPS_RESET;
      minp_r          <= MINP_RESET;
      points_held_r   <= '0;
      clusters_open_r <= '0;
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      out_valid_r     <= 1'b0;
      out_last_r      <= 1'b0;
      best_valid_r    <= 1'b0;
      rd_idx_r        <= '0;
      sidx_r          <= '0;
      kept_r          <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_EPS_MM:   eps_r  <= cfg_data;
          REG_MIN_SIZE: minp_r <= MINP_W'(cfg_data);
          default: ;
        endcase
      end

      v1_r <= issue_en;
      v2_r <= v1_r;
      if (issue_en) begin
        rd_idx_r <= rd_idx_r + PCNT_W'(1);
      end
      if (v2_r && hit && (!best_valid_r || cl2_r < best_r)) begin
        best_valid_r <= 1'b1;
        best_r       <= cl2_r;
      end

      if (push) begin
        out_valid_r <= 1'b1;
        out_r       <= pend_r;
        out_last_r  <= (state_r == ST_FLUSH);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r          <= in_tdata[COORD_W-1:0];
            y_r          <= in_tdata[2*COORD_W-1:COORD_W];
            last_r       <= in_tlast;
            rd_idx_r     <= '0;
            best_valid_r <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!issue_en && !v1_r && !v2_r) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          pend_r.kind          <= KIND_ASSIGN;
          pend_r.cluster_id    <= drop_c ? '0 : ID_W'(id_c);
          pend_r.cluster_count <= '0;
          pend_r.kept_index    <= '0;
          pend_r.dropped       <= drop_c;
          id_r                 <= id_c;
          sidx_r               <= '0;
          kept_r               <= '0;
          if (!drop_c) begin
            points_held_r <= points_held_r + PCNT_W'(1);
          end
          if (new_c) begin
            clusters_open_r <= clusters_open_r + COPEN_W'(1);
          end
          if (!drop_c && !new_c) begin
            state_r <= ST_INC;
          end else begin
            state_r <= last_r ? ST_SUM_RD : ST_FLUSH;
          end
        end
        ST_INC: begin
          state_r <= last_r ? ST_SUM_RD : ST_FLUSH;
        end
        ST_SUM_RD: begin
          if (sum_more) begin
            state_r <= ST_SUM_CHK;
          end else begin
            points_held_r   <= '0;
            clusters_open_r <= '0;
            state_r         <= ST_FLUSH;
          end
        end
        ST_SUM_CHK: begin
          if (!keep) begin
            sidx_r  <= sidx_r + COPEN_W'(1);
            state_r <= ST_SUM_RD;
          end else if (out_free) begin
            pend_r  <= summary;
            kept_r  <= kept_r + COPEN_W'(1);
            sidx_r  <= sidx_r + COPEN_W'(1);
            state_r <= ST_SUM_RD;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_points_bound: assert property (@(posedge clk) disable iff (!rst_n)
    points_held_r <= PCNT_W'(PT_DEPTH))
    else $error("point count beyond store depth");

  a_clusters_bound: assert property (@(posedge clk) disable iff (!rst_n)
    clusters_open_r <= COPEN_W'(MAX_CLUSTERS))
    else $error("open cluster count beyond list depth");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> state_r == ST_SCAN)
    else $error("compare stage active outside scan");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && last_r) |-> (points_held_r == '0 && clusters_open_r == '0))
    else $error("frame not cleared after last point");

  a_no_scan_on_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM_CHK && keep && !out_free) |=> (state_r == ST_SUM_CHK))
    else $error("summary lost under output stall");

endmodule
